// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

   // Result kinds carried on rsp_tuser
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_NUL = 8'd0;
   localparam logic [7:0] CHAR_PAD = 8'd61;

   // Command depth between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One command: up to three decoded bytes, then optional done or error word
   typedef struct packed {
      logic [1:0]  nbytes;   // 0..3 bytes, byte 0 in bits 23:16
      logic [23:0] bytes;
      logic        done;
      logic        error;
   } cmd_type;

   // Alphabet lookup: valid flag plus 6-bit value
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
         s.value = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         s.value = 6'(c - 8'd71);
      end else if (c >= 8'd48 && c <= 8'd57) begin
         s.value = 6'(c + 8'd4);
      end else if (c == 8'd43) begin
         s.value = 6'd62;
      end else if (c == 8'd47) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
module b64d_front import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [1:0]  phase_ff, phase_in;
   logic [17:0] held_ff, held_in;
   logic        pad3_ff, pad3_in;
   logic        skip_ff, skip_in;

   logic        accept;
   logic [7:0]  c;
   sextet_type  sx;
   logic        is_nul, is_pad, err;
   logic [5:0]  s1, s2, s3, s4;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign sx         = sextet_of(c);
   assign is_nul     = (c == CHAR_NUL);
   assign is_pad     = (c == CHAR_PAD);

   assign s1 = held_ff[17:12];
   assign s2 = held_ff[11:6];
   assign s3 = held_ff[5:0];
   assign s4 = is_pad ? 6'd0 : sx.value;

   // Classify the character against the group position
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      pad3_in  = pad3_ff;
      skip_in  = skip_ff;
      push     = 1'b0;
      push_cmd = '0;
      err      = 1'b0;
      if (accept) begin
         if (skip_ff) begin
            if (is_nul) skip_in = 1'b0;
         end else begin
            case (phase_ff)
               2'd0: begin
                  if (is_nul) begin
                     push          = 1'b1;
                     push_cmd.done = 1'b1;
                  end else if (!sx.valid) begin
                     err = 1'b1;
                  end else begin
                     held_in  = {sx.value, 12'd0};
                     phase_in = 2'd1;
                  end
               end
               2'd1: begin
                  if (!sx.valid) begin
                     err = 1'b1;
                  end else begin
                     held_in[11:6] = sx.value;
                     phase_in      = 2'd2;
                  end
               end
               2'd2: begin
                  if (is_pad) begin
                     pad3_in  = 1'b1;
                     phase_in = 2'd3;
                  end else if (!sx.valid) begin
                     err = 1'b1;
                  end else begin
                     held_in[5:0] = sx.value;
                     phase_in     = 2'd3;
                  end
               end
               default: begin
                  if (!is_pad && !sx.valid) begin
                     err = 1'b1;
                  end else begin
                     push            = 1'b1;
                     push_cmd.bytes  = {s1, s2, s3, s4};
                     push_cmd.nbytes = pad3_ff ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
                     push_cmd.done   = is_pad;
                     phase_in        = 2'd0;
                     held_in         = '0;
                     pad3_in         = 1'b0;
                     if (is_pad) skip_in = 1'b1;
                  end
               end
            endcase
            // Bad character ends the string; skip to NUL unless it was the NUL
            if (err) begin
               push           = 1'b1;
               push_cmd       = '0;
               push_cmd.error = 1'b1;
               phase_in       = 2'd0;
               held_in        = '0;
               pad3_in        = 1'b0;
               skip_in        = !is_nul;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         held_ff  <= '0;
         pad3_ff  <= 1'b0;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         pad3_ff  <= pad3_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
module b64d_queue import b64d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in;
   logic [QPTR_W-1:0]     rd_ff, rd_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue write while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> !empty)
      else $error("queue count lost a word");

endmodule

// ===== hw/rtl/b64d_back.sv =====
module b64d_back import b64d_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  cmd_type                head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output kind_type               out_kind,
   output logic [7:0]             out_byte,
   output logic [COUNT_WIDTH-1:0] out_count,
   output logic                   rsp_tlast
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                   valid_ff, valid_in;
   kind_type               kind_ff, kind_in;
   logic [7:0]             byte_ff, byte_in;
   logic [COUNT_WIDTH-1:0] ocnt_ff, ocnt_in;
   logic                   last_ff, last_in;
   logic [1:0]             idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic       load;
   logic [2:0] n_words;
   logic       is_last;

   assign load    = !empty && (!valid_ff || rsp_tready);
   assign n_words = {1'b0, head.nbytes} + {2'b0, head.done} + {2'b0, head.error};
   assign is_last = ({1'b0, idx_ff} == 3'(n_words - 3'd1));
   assign pop     = load && is_last;

   // Expand the head command into one result word per cycle unless rsp_tready stalls
   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      ocnt_in  = ocnt_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : 2'(idx_ff + 1'b1);
         byte_in  = '0;
         ocnt_in  = '0;
         if ({1'b0, idx_ff} < {1'b0, head.nbytes}) begin
            kind_in = KIND_BYTE;
            case (idx_ff)
               2'd0:    byte_in = head.bytes[23:16];
               2'd1:    byte_in = head.bytes[15:8];
               default: byte_in = head.bytes[7:0];
            endcase
            if (total_ff != COUNT_MAX) total_in = total_ff + 1'b1;
         end else if (head.error) begin
            kind_in  = KIND_ERROR;
            total_in = '0;
         end else begin
            kind_in  = KIND_DONE;
            ocnt_in  = total_ff;
            total_in = '0;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      ocnt_ff <= ocnt_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign out_kind   = kind_ff;
   assign out_byte   = byte_ff;
   assign out_count  = ocnt_ff;
   assign rsp_tlast  = last_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_BYTE) |-> last_ff)
      else $error("done or error word not marked last");

   a_count_only_done: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_DONE) |-> (ocnt_ff == '0))
      else $error("count on a word that is not done");

   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      (load && !empty && ({1'b0, idx_ff} >= {1'b0, head.nbytes})) |=> (total_ff == '0))
      else $error("byte total not cleared at end of string");

endmodule

// ===== hw/rtl/base64_decoder_core.sv =====
// Streaming base64 decoder (standard alphabet A-Z a-z 0-9 + /, '=' padding).
// One character of a NUL-terminated string is taken per req_ word, one per
// cycle while the queue has room. Each fourth character of a group gives its
// decoded bytes, one rsp_ word each; a closing '=' group or a NUL at a group
// boundary adds a done word carrying the string's byte count (saturating at
// 2^COUNT_WIDTH-1); a bad character or a NUL inside a group gives an error
// word. After a '=' done or an error on a non-NUL character, characters are
// dropped up to and including the next NUL. rsp_tlast marks the final word
// caused by one input character. The front stage classifies a character
// combinationally and hands a command to a four-entry queue; the back stage
// drives one result word per cycle while rsp_tready is high, so a group of
// four characters yields at most three words and the block sustains one
// character per cycle; commands pass a queue slot, then the output register.
module base64_decoder_core import b64d_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] char_code
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] data_byte, [COUNT_WIDTH+7:8] byte_count, zero fill above
   output logic [((8+COUNT_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   output logic [1:0]                           rsp_tuser,  // [1:0] kind
   output logic                                 rsp_tlast   // last
);

   localparam int DATA_W = ((8 + COUNT_WIDTH + 7) / 8) * 8;

   logic                   push, pop, full, empty;
   cmd_type                push_cmd, head;
   kind_type               out_kind;
   logic [7:0]             out_byte;
   logic [COUNT_WIDTH-1:0] out_count;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   b64d_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_kind   (out_kind),
      .out_byte   (out_byte),
      .out_count  (out_count),
      .rsp_tlast  (rsp_tlast)
   );

   // Pack result word
   assign rsp_tdata = DATA_W'({out_count, out_byte});
   assign rsp_tuser = out_kind;

endmodule
